FILE: hw/rtl/cpt_pkg.sv
`timescale 1ns / 1ps

package cpt_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int DOT_W      = PROD_W + 2;
    localparam int SPLIT_W    = DOT_W / 2;
    localparam int PART_W     = DOT_W + SPLIT_W + 1;
    localparam int EDGE_W     = DOT_W + 1;
    localparam int CROSS_W    = 2 * DOT_W + 1;
    localparam int DEN_W      = CROSS_W + 2;
    localparam int RATIO_FRAC = 16;
    localparam int RATIO_W    = RATIO_FRAC + 1;
    localparam int REGION_W   = 3;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [DOT_W-1:0]      dot_t;
    typedef logic signed [PART_W-1:0]     part_t;
    typedef logic signed [EDGE_W-1:0]     edge_t;
    typedef logic signed [CROSS_W-1:0]    cross_t;
    typedef logic signed [DEN_W-1:0]      den_t;
    typedef logic [RATIO_W-1:0]           ratio_t;

    localparam ratio_t RATIO_ONE = ratio_t'(1 << RATIO_FRAC);

    typedef enum logic [REGION_W-1:0] {
        REGION_A  = 3'd0,
        REGION_B  = 3'd1,
        REGION_C  = 3'd2,
        REGION_AB = 3'd3,
        REGION_AC = 3'd4,
        REGION_BC = 3'd5,
        REGION_IN = 3'd6
    } region_t;

    typedef struct packed {
        coord_t query_x;
        coord_t query_y;
        coord_t query_z;
        coord_t vert_a_x;
        coord_t vert_a_y;
        coord_t vert_a_z;
        coord_t vert_b_x;
        coord_t vert_b_y;
        coord_t vert_b_z;
        coord_t vert_c_x;
        coord_t vert_c_y;
        coord_t vert_c_z;
    } query_t;

    typedef struct packed {
        coord_t              near_x;
        coord_t              near_y;
        coord_t              near_z;
        logic [REGION_W-1:0] region;
        logic                degenerate;
    } near_t;

    typedef struct packed {
        coord_t [2:0] a;
        coord_t [2:0] b;
        coord_t [2:0] c;
        diff_t  [2:0] ab;
        diff_t  [2:0] ac;
        diff_t  [2:0] bc;
    } vtx_t;

    typedef struct packed {
        dot_t d1;
        dot_t d2;
        dot_t d3;
        dot_t d4;
        dot_t d5;
        dot_t d6;
    } dots_t;

    typedef struct packed {
        cross_t va;
        cross_t vb;
        cross_t vc;
        edge_t  ee;
        edge_t  ff;
    } cross_set_t;

    typedef struct packed {
        coord_t [2:0] base;
        diff_t  [2:0] e1;
        diff_t  [2:0] e2;
        region_t      region;
    } geo_t;

    typedef struct packed {
        geo_t geo;
        den_t num1;
        den_t num2;
        den_t den;
        logic use1;
        logic use2;
    } sel_t;

    function automatic diff_t sub_c(input coord_t x, input coord_t y);
        return $signed({x[COORD_BITS-1], x}) - $signed({y[COORD_BITS-1], y});
    endfunction

endpackage

FILE: hw/rtl/cpt_query_if.sv
`timescale 1ns / 1ps

interface cpt_query_if import cpt_pkg::*; ();
    logic   valid;
    logic   ready;
    query_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/cpt_near_if.sv
`timescale 1ns / 1ps

interface cpt_near_if import cpt_pkg::*; ();
    logic  valid;
    logic  ready;
    near_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/closest_point_on_triangle_top.sv
// Closest point on a triangle, 3D, signed Q8.8 coordinates.
// query : request channel carrying the point P and vertices A, B, C.
// result: nearest point on the triangle, its Voronoi region (vertex,
//         edge or interior) and a flag for a zero ratio divisor.
// Both channels move a request when valid and ready are high together.
// Throughput is one request per cycle while the output is not stalled;
// from accept to result valid the stages are: edge vectors and dot
// products, the split cross-term multiplies, region select, the two
// pipelined restoring dividers (one quotient bit per stage), then the
// weighted sum, rounding and clamp. The divider chain sets the depth.
// The whole pipeline advances on one enable: it moves whenever the
// output register is empty or being drained. When the receiver holds
// ready low with a result waiting, every stage holds, bubbles included,
// and query.ready drops until the result is taken. Nothing is dropped or
// repeated. Reset clears all valid bits; no request is in flight after
// reset and the block takes a request in the first cycle out of reset.
`timescale 1ns / 1ps

module closest_point_on_triangle_top import cpt_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    cpt_query_if.sink   query,
    cpt_near_if.source  result
);

    logic       en;

    logic       geo_valid;
    dots_t      geo_dots;
    vtx_t       geo_vtx;

    logic       crs_valid;
    dots_t      crs_dots;
    vtx_t       crs_vtx;
    cross_set_t crs_set;

    logic       sel_valid;
    sel_t       sel;

    logic       rat_valid;
    geo_t       rat_geo;
    ratio_t     rat_r1;
    ratio_t     rat_r2;
    logic       rat_deg;

    // advance unless a finished result is stalled at the output
    assign en          = !result.valid || result.ready;
    assign query.ready = en;

    cpt_geom u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (query.valid),
        .in_data   (query.data),
        .out_valid (geo_valid),
        .out_dots  (geo_dots),
        .out_vtx   (geo_vtx)
    );

    // cross terms va, vb, vc and edge terms ee, ff from the six dot products
    cpt_cross u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (geo_valid),
        .in_dots   (geo_dots),
        .in_vtx    (geo_vtx),
        .out_valid (crs_valid),
        .out_dots  (crs_dots),
        .out_vtx   (crs_vtx),
        .out_cross (crs_set)
    );

    // region tests in priority order, pick base and edge directions
    cpt_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (crs_valid),
        .in_dots   (crs_dots),
        .in_vtx    (crs_vtx),
        .in_cross  (crs_set),
        .out_valid (sel_valid),
        .out_sel   (sel)
    );

    // two quotient lanes; the interior case uses both
    cpt_ratio u_ratio (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sel_valid),
        .in_sel    (sel),
        .out_valid (rat_valid),
        .out_geo   (rat_geo),
        .out_r1    (rat_r1),
        .out_r2    (rat_r2),
        .out_deg   (rat_deg)
    );

    // base + e1*r1 + e2*r2, round, saturate; last stage is the output register
    cpt_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rat_valid),
        .in_geo    (rat_geo),
        .in_r1     (rat_r1),
        .in_r2     (rat_r2),
        .in_deg    (rat_deg),
        .out_valid (result.valid),
        .out_data  (result.data)
    );

endmodule

FILE: hw/rtl/cpt_geom.sv
`timescale 1ns / 1ps

module cpt_geom import cpt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_valid,
    input  query_t in_data,
    output logic   out_valid,
    output dots_t  out_dots,
    output vtx_t   out_vtx
);

    coord_t p [3];
    coord_t a [3];
    coord_t b [3];
    coord_t c [3];

    logic [2:0] v_reg;
    vtx_t       vtx1_reg;
    vtx_t       vtx2_reg;
    vtx_t       vtx3_reg;
    diff_t      pv_reg [3][3];
    prod_t      pr_reg [6][3];
    dot_t       d_reg  [6];

    always_comb
    begin
        p[0] = in_data.query_x;
        p[1] = in_data.query_y;
        p[2] = in_data.query_z;
        a[0] = in_data.vert_a_x;
        a[1] = in_data.vert_a_y;
        a[2] = in_data.vert_a_z;
        b[0] = in_data.vert_b_x;
        b[1] = in_data.vert_b_y;
        b[2] = in_data.vert_b_z;
        c[0] = in_data.vert_c_x;
        c[1] = in_data.vert_c_y;
        c[2] = in_data.vert_c_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    // edge and point vectors
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                vtx1_reg.a[i]  <= a[i];
                vtx1_reg.b[i]  <= b[i];
                vtx1_reg.c[i]  <= c[i];
                vtx1_reg.ab[i] <= sub_c(b[i], a[i]);
                vtx1_reg.ac[i] <= sub_c(c[i], a[i]);
                vtx1_reg.bc[i] <= sub_c(c[i], b[i]);
                pv_reg[0][i]   <= sub_c(p[i], a[i]);
                pv_reg[1][i]   <= sub_c(p[i], b[i]);
                pv_reg[2][i]   <= sub_c(p[i], c[i]);
            end
        end
    end

    // per-axis products; d1, d3, d5 use AB, d2, d4, d6 use AC
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vtx2_reg <= vtx1_reg;
            for (int k = 0; k < 6; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (k % 2 == 0)
                        pr_reg[k][i] <= $signed(vtx1_reg.ab[i]) * pv_reg[k/2][i];
                    else
                        pr_reg[k][i] <= $signed(vtx1_reg.ac[i]) * pv_reg[k/2][i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vtx3_reg <= vtx2_reg;
            for (int k = 0; k < 6; k++)
            begin
                d_reg[k] <= dot_t'(pr_reg[k][0]) + dot_t'(pr_reg[k][1])
                          + dot_t'(pr_reg[k][2]);
            end
        end
    end

    assign out_valid   = v_reg[2];
    assign out_vtx     = vtx3_reg;
    assign out_dots.d1 = d_reg[0];
    assign out_dots.d2 = d_reg[1];
    assign out_dots.d3 = d_reg[2];
    assign out_dots.d4 = d_reg[3];
    assign out_dots.d5 = d_reg[4];
    assign out_dots.d6 = d_reg[5];

endmodule

FILE: hw/rtl/cpt_cross.sv
`timescale 1ns / 1ps

module cpt_cross import cpt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  dots_t      in_dots,
    input  vtx_t       in_vtx,
    output logic       out_valid,
    output dots_t      out_dots,
    output vtx_t       out_vtx,
    output cross_set_t out_cross
);

    dot_t mx [6];
    dot_t my [6];

    logic [2:0] v_reg;
    dots_t      dots1_reg;
    dots_t      dots2_reg;
    dots_t      dots3_reg;
    vtx_t       vtx1_reg;
    vtx_t       vtx2_reg;
    vtx_t       vtx3_reg;
    part_t      pl_reg [6];
    part_t      ph_reg [6];
    cross_t     pf_reg [6];
    cross_set_t cr_reg;

    // products d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4
    always_comb
    begin
        mx[0] = in_dots.d1;
        my[0] = in_dots.d4;
        mx[1] = in_dots.d3;
        my[1] = in_dots.d2;
        mx[2] = in_dots.d5;
        my[2] = in_dots.d2;
        mx[3] = in_dots.d1;
        my[3] = in_dots.d6;
        mx[4] = in_dots.d3;
        my[4] = in_dots.d6;
        mx[5] = in_dots.d5;
        my[5] = in_dots.d4;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    // split the second operand into a signed high and an unsigned low half
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dots1_reg <= in_dots;
            vtx1_reg  <= in_vtx;
            for (int k = 0; k < 6; k++)
            begin
                pl_reg[k] <= mx[k] * $signed({1'b0, my[k][SPLIT_W-1:0]});
                ph_reg[k] <= mx[k] * $signed(my[k][DOT_W-1:SPLIT_W]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dots2_reg <= dots1_reg;
            vtx2_reg  <= vtx1_reg;
            for (int k = 0; k < 6; k++)
            begin
                pf_reg[k] <= (cross_t'(ph_reg[k]) <<< SPLIT_W) + cross_t'(pl_reg[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dots3_reg <= dots2_reg;
            vtx3_reg  <= vtx2_reg;
            cr_reg.vc <= pf_reg[0] - pf_reg[1];
            cr_reg.vb <= pf_reg[2] - pf_reg[3];
            cr_reg.va <= pf_reg[4] - pf_reg[5];
            cr_reg.ee <= edge_t'(dots2_reg.d4) - edge_t'(dots2_reg.d3);
            cr_reg.ff <= edge_t'(dots2_reg.d5) - edge_t'(dots2_reg.d6);
        end
    end

    assign out_valid = v_reg[2];
    assign out_dots  = dots3_reg;
    assign out_vtx   = vtx3_reg;
    assign out_cross = cr_reg;

endmodule

FILE: hw/rtl/cpt_select.sv
`timescale 1ns / 1ps

module cpt_select import cpt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  dots_t      in_dots,
    input  vtx_t       in_vtx,
    input  cross_set_t in_cross,
    output logic       out_valid,
    output sel_t       out_sel
);

    logic v_reg;
    sel_t sel_reg;
    sel_t sel_next;

    logic c_a, c_b, c_c, c_ab, c_ac, c_bc;

    function automatic logic le0(input logic neg, input logic zero);
        return neg | zero;
    endfunction

    always_comb
    begin
        c_a  = le0(in_dots.d1[DOT_W-1], in_dots.d1 == '0)
             & le0(in_dots.d2[DOT_W-1], in_dots.d2 == '0);
        c_b  = !in_dots.d3[DOT_W-1] & le0(in_cross.ee[EDGE_W-1], in_cross.ee == '0);
        c_c  = !in_dots.d6[DOT_W-1] & le0(in_cross.ff[EDGE_W-1], in_cross.ff == '0);
        c_ab = le0(in_cross.vc[CROSS_W-1], in_cross.vc == '0) & !in_dots.d1[DOT_W-1]
             & le0(in_dots.d3[DOT_W-1], in_dots.d3 == '0);
        c_ac = le0(in_cross.vb[CROSS_W-1], in_cross.vb == '0) & !in_dots.d2[DOT_W-1]
             & le0(in_dots.d6[DOT_W-1], in_dots.d6 == '0);
        c_bc = le0(in_cross.va[CROSS_W-1], in_cross.va == '0)
             & !in_cross.ee[EDGE_W-1] & !in_cross.ff[EDGE_W-1];

        sel_next.geo.base   = in_vtx.a;
        sel_next.geo.e1     = in_vtx.ab;
        sel_next.geo.e2     = in_vtx.ac;
        sel_next.geo.region = REGION_IN;
        sel_next.num1       = in_cross.vb;
        sel_next.num2       = in_cross.vc;
        sel_next.den        = den_t'(in_cross.va) + den_t'(in_cross.vb)
                            + den_t'(in_cross.vc);
        sel_next.use1       = 1'b0;
        sel_next.use2       = 1'b0;

        if (c_a)
        begin
            sel_next.geo.region = REGION_A;
        end
        else if (c_b)
        begin
            sel_next.geo.region = REGION_B;
            sel_next.geo.base   = in_vtx.b;
        end
        else if (c_c)
        begin
            sel_next.geo.region = REGION_C;
            sel_next.geo.base   = in_vtx.c;
        end
        else if (c_ab)
        begin
            sel_next.geo.region = REGION_AB;
            sel_next.num1       = den_t'(in_dots.d1);
            sel_next.den        = den_t'(in_dots.d1) - den_t'(in_dots.d3);
            sel_next.use1       = 1'b1;
        end
        else if (c_ac)
        begin
            sel_next.geo.region = REGION_AC;
            sel_next.geo.e1     = in_vtx.ac;
            sel_next.num1       = den_t'(in_dots.d2);
            sel_next.den        = den_t'(in_dots.d2) - den_t'(in_dots.d6);
            sel_next.use1       = 1'b1;
        end
        else if (c_bc)
        begin
            sel_next.geo.region = REGION_BC;
            sel_next.geo.base   = in_vtx.b;
            sel_next.geo.e1     = in_vtx.bc;
            sel_next.num1       = den_t'(in_cross.ee);
            sel_next.den        = den_t'(in_cross.ee) + den_t'(in_cross.ff);
            sel_next.use1       = 1'b1;
        end
        else
        begin
            sel_next.use1 = 1'b1;
            sel_next.use2 = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sel_reg <= sel_next;
        end
    end

    assign out_valid = v_reg;
    assign out_sel   = sel_reg;

endmodule

FILE: hw/rtl/cpt_ratio.sv
`timescale 1ns / 1ps

module cpt_ratio import cpt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_valid,
    input  sel_t   in_sel,
    output logic   out_valid,
    output geo_t   out_geo,
    output ratio_t out_r1,
    output ratio_t out_r2,
    output logic   out_deg
);

    typedef struct packed {
        logic [DEN_W-1:0]      rem;
        logic [DEN_W-1:0]      dv;
        logic [RATIO_FRAC-1:0] q;
        logic                  fixed;
        ratio_t                fval;
    } lane_t;

    localparam int STEPS = RATIO_FRAC;

    den_t num [2];
    logic use_l [2];
    logic den_zero;

    logic             v0_reg;
    geo_t             g0_reg;
    logic             deg0_reg;
    logic [DEN_W-1:0] an_reg [2];
    logic [DEN_W-1:0] ad_reg;
    logic             act_reg [2];

    logic [STEPS:0] v_reg;
    geo_t           g_reg   [STEPS+1];
    logic           deg_reg [STEPS+1];
    lane_t          ln_reg  [STEPS+1][2];

    always_comb
    begin
        num[0]   = in_sel.num1;
        num[1]   = in_sel.num2;
        use_l[0] = in_sel.use1;
        use_l[1] = in_sel.use2;
        den_zero = (in_sel.den == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v_reg  <= '0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v_reg  <= {v_reg[STEPS-1:0], v0_reg};
        end
    end

    // signs, magnitudes and the cases that skip the division
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g0_reg   <= in_sel.geo;
            deg0_reg <= (in_sel.use1 | in_sel.use2) & den_zero;
            ad_reg   <= in_sel.den[DEN_W-1] ? DEN_W'(-in_sel.den) : DEN_W'(in_sel.den);
            for (int l = 0; l < 2; l++)
            begin
                an_reg[l]  <= num[l][DEN_W-1] ? DEN_W'(-num[l]) : DEN_W'(num[l]);
                act_reg[l] <= use_l[l] & !den_zero & (num[l] != '0)
                            & (num[l][DEN_W-1] == in_sel.den[DEN_W-1]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_reg[0]   <= g0_reg;
            deg_reg[0] <= deg0_reg;
            for (int l = 0; l < 2; l++)
            begin
                ln_reg[0][l].rem <= an_reg[l];
                ln_reg[0][l].dv  <= ad_reg;
                ln_reg[0][l].q   <= '0;
                if (!act_reg[l])
                begin
                    ln_reg[0][l].fixed <= 1'b1;
                    ln_reg[0][l].fval  <= '0;
                end
                else if (an_reg[l] >= ad_reg)
                begin
                    ln_reg[0][l].fixed <= 1'b1;
                    ln_reg[0][l].fval  <= RATIO_ONE;
                end
                else
                begin
                    ln_reg[0][l].fixed <= 1'b0;
                    ln_reg[0][l].fval  <= '0;
                end
            end
        end
    end

    // one quotient bit per stage, restoring division
    for (genvar s = 0; s < STEPS; s++)
    begin : g_step
        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            logic [DEN_W:0] rem2;
            logic [DEN_W:0] dvx;
            lane_t          ln_next;

            always_comb
            begin
                rem2    = {ln_reg[s][l].rem, 1'b0};
                dvx     = {1'b0, ln_reg[s][l].dv};
                ln_next = ln_reg[s][l];
                if (rem2 >= dvx)
                begin
                    ln_next.rem = DEN_W'(rem2 - dvx);
                    ln_next.q   = {ln_reg[s][l].q[RATIO_FRAC-2:0], 1'b1};
                end
                else
                begin
                    ln_next.rem = rem2[DEN_W-1:0];
                    ln_next.q   = {ln_reg[s][l].q[RATIO_FRAC-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    ln_reg[s+1][l] <= ln_next;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                g_reg[s+1]   <= g_reg[s];
                deg_reg[s+1] <= deg_reg[s];
            end
        end
    end

    assign out_valid = v_reg[STEPS];
    assign out_geo   = g_reg[STEPS];
    assign out_deg   = deg_reg[STEPS];
    assign out_r1    = ln_reg[STEPS][0].fixed ? ln_reg[STEPS][0].fval
                                              : {1'b0, ln_reg[STEPS][0].q};
    assign out_r2    = ln_reg[STEPS][1].fixed ? ln_reg[STEPS][1].fval
                                              : {1'b0, ln_reg[STEPS][1].q};

endmodule

FILE: hw/rtl/cpt_finish.sv
`timescale 1ns / 1ps

module cpt_finish import cpt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_valid,
    input  geo_t   in_geo,
    input  ratio_t in_r1,
    input  ratio_t in_r2,
    input  logic   in_deg,
    output logic   out_valid,
    output near_t  out_data
);

    localparam int EP_W  = DIFF_W + RATIO_W + 1;
    localparam int T_W   = DIFF_W + RATIO_W + 2;
    localparam int RND_W = T_W - RATIO_FRAC;

    typedef logic signed [EP_W-1:0]  ep_t;
    typedef logic signed [T_W-1:0]   t_t;
    typedef logic signed [RND_W-1:0] rnd_t;

    localparam rnd_t RND_HI = rnd_t'((1 << (COORD_BITS - 1)) - 1);
    localparam rnd_t RND_LO = -RND_HI - rnd_t'(1);
    localparam t_t   HALF   = t_t'(1 << (RATIO_FRAC - 1));

    logic    v1_reg;
    ep_t     p1_reg [3];
    ep_t     p2_reg [3];
    coord_t  base_reg [3];
    region_t region_reg;
    logic    deg_reg;

    logic   v2_reg;
    coord_t nc_reg [3];
    logic [REGION_W-1:0] region2_reg;
    logic   deg2_reg;

    t_t     t   [3];
    rnd_t   rnd [3];
    coord_t sat [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            region_reg <= in_geo.region;
            deg_reg    <= in_deg;
            for (int i = 0; i < 3; i++)
            begin
                base_reg[i] <= $signed(in_geo.base[i]);
                p1_reg[i]   <= $signed(in_geo.e1[i]) * $signed({1'b0, in_r1});
                p2_reg[i]   <= $signed(in_geo.e2[i]) * $signed({1'b0, in_r2});
            end
        end
    end

    // round half up at the ratio point, then clamp
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            t[i]   = (t_t'(base_reg[i]) <<< RATIO_FRAC) + t_t'(p1_reg[i])
                   + t_t'(p2_reg[i]) + HALF;
            rnd[i] = t[i][T_W-1:RATIO_FRAC];
            if (rnd[i] > RND_HI)
                sat[i] = RND_HI[COORD_BITS-1:0];
            else if (rnd[i] < RND_LO)
                sat[i] = RND_LO[COORD_BITS-1:0];
            else
                sat[i] = rnd[i][COORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                nc_reg[i] <= sat[i];
            end
            region2_reg <= region_reg;
            deg2_reg    <= deg_reg;
        end
    end

    assign out_valid           = v2_reg;
    assign out_data.near_x     = nc_reg[0];
    assign out_data.near_y     = nc_reg[1];
    assign out_data.near_z     = nc_reg[2];
    assign out_data.region     = region2_reg;
    assign out_data.degenerate = deg2_reg;

endmodule
